// ----- rtl/voc_pkg.sv -----
// Shared types, codes and helper functions of the sound sample decoder.
`timescale 1ns / 1ps

package voc_pkg;

    localparam logic [2:0] MODE_PCM_U8  = 3'd0;
    localparam logic [2:0] MODE_ADPCM4  = 3'd1;
    localparam logic [2:0] MODE_ADPCM26 = 3'd2;
    localparam logic [2:0] MODE_ADPCM2  = 3'd3;
    localparam logic [2:0] MODE_PCM_S16 = 3'd4;

    localparam logic [2:0] KIND_U8   = 3'd0;
    localparam logic [2:0] KIND_A4   = 3'd1;
    localparam logic [2:0] KIND_A26  = 3'd2;
    localparam logic [2:0] KIND_A2   = 3'd3;
    localparam logic [2:0] KIND_S16  = 3'd4;
    localparam logic [2:0] KIND_NONE = 3'd5;

    localparam logic [7:0] REF_RESET  = 8'h80;
    localparam logic [5:0] STEP_RESET = 6'd1;
    localparam logic [6:0] CEIL_A4    = 7'h08;
    localparam logic [6:0] CEIL_A26   = 7'h10;
    localparam logic [6:0] CEIL_A2    = 7'h20;

    typedef struct packed {
        logic [2:0] kind;
        logic       start;
        logic [1:0] last_idx;
        logic [7:0] data;
    } cmd_t;

    function automatic logic [15:0] expand_u8(input logic [7:0] s);
        expand_u8 = {{2{~s[7]}}, s[6:0], 7'd0};
    endfunction

    function automatic logic [5:0] sat_double(input logic [5:0] s, input logic [6:0] ceil);
        logic [6:0] d;
        d = {s, 1'b0};
        sat_double = (d > ceil) ? ceil[5:0] : d[5:0];
    endfunction

    function automatic logic [5:0] halve_min1(input logic [5:0] s);
        halve_min1 = (s[5:1] == 5'd0) ? STEP_RESET : {1'b0, s[5:1]};
    endfunction

endpackage

// ----- rtl/voc_front.sv -----
// Front end: holds the codec mode and turns each input byte into a command.
`timescale 1ns / 1ps

module voc_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [2:0]      cfg_data,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [7:0]      s_tdata,
    input  logic            s_tuser,
    output logic            push,
    output voc_pkg::cmd_t   push_cmd,
    input  logic            q_ready
);
    import voc_pkg::*;

    logic [2:0] mode_reg;
    logic [2:0] mode_next;

    assign cfg_ready = 1'b1;
    assign s_tready  = q_ready;
    assign push      = s_tvalid && q_ready;

    always_comb
    begin
        mode_next = mode_reg;
        if (cfg_valid)
        begin
            mode_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_ADPCM4;
        end
        else
        begin
            mode_reg <= mode_next;
        end
    end

    always_comb
    begin
        push_cmd.data  = s_tdata;
        push_cmd.start = s_tuser;
        case (mode_reg)
            MODE_PCM_U8:
            begin
                push_cmd.kind     = KIND_U8;
                push_cmd.last_idx = 2'd0;
            end
            MODE_ADPCM4:
            begin
                push_cmd.kind     = KIND_A4;
                push_cmd.last_idx = s_tuser ? 2'd0 : 2'd1;
            end
            MODE_ADPCM26:
            begin
                push_cmd.kind     = KIND_A26;
                push_cmd.last_idx = s_tuser ? 2'd0 : 2'd2;
            end
            MODE_ADPCM2:
            begin
                push_cmd.kind     = KIND_A2;
                push_cmd.last_idx = s_tuser ? 2'd0 : 2'd3;
            end
            MODE_PCM_S16:
            begin
                push_cmd.kind     = KIND_S16;
                push_cmd.last_idx = 2'd0;
            end
            default:
            begin
                push_cmd.kind     = KIND_NONE;
                push_cmd.last_idx = 2'd0;
            end
        endcase
    end

endmodule

// ----- rtl/voc_queue.sv -----
// Two-entry command queue between the front end and the back end.
`timescale 1ns / 1ps

module voc_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  voc_pkg::cmd_t   push_cmd,
    output logic            q_ready,
    input  logic            pop,
    output logic            q_valid,
    output voc_pkg::cmd_t   head_cmd
);
    import voc_pkg::*;

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign q_ready  = (count_reg != 2'd2);
    assign q_valid  = (count_reg != 2'd0);
    assign head_cmd = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ----- rtl/voc_back.sv -----
// Back end: decodes one code per cycle unless the output stalls, and drives the registered sample output.
`timescale 1ns / 1ps

module voc_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    input  voc_pkg::cmd_t   head_cmd,
    output logic            pop,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [15:0]     m_tdata,
    output logic            m_tlast
);
    import voc_pkg::*;

    logic        busy_reg;
    logic        busy_next;
    cmd_t        cmd_reg;
    logic [1:0]  idx_reg;
    logic [1:0]  idx_next;
    logic [7:0]  ref_reg;
    logic [7:0]  ref_next;
    logic [5:0]  step_reg;
    logic [5:0]  step_next;
    logic        phase_reg;
    logic        phase_next;
    logic [7:0]  hold_reg;
    logic [7:0]  hold_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [15:0] out_data_reg;
    logic [15:0] out_data_next;
    logic        out_last_reg;
    logic        out_last_next;

    logic        step_fire;
    logic        last_step;
    logic [3:0]  code;
    logic [2:0]  mag;
    logic        neg;
    logic        do_move;
    logic [8:0]  delta;
    logic [8:0]  prod;
    logic [4:0]  half;
    logic [5:0]  step_adp;
    logic [10:0] moved;
    logic [7:0]  ref_adp;
    logic        produce;
    logic [15:0] sample;

    assign step_fire = busy_reg && (!out_valid_reg || m_tready);
    assign last_step = step_fire && (idx_reg == cmd_reg.last_idx);
    assign pop       = q_valid && (!busy_reg || last_step);
    assign half      = step_reg[5:1];

    always_comb
    begin
        code = 4'd0;
        case (cmd_reg.kind)
            KIND_A4:
            begin
                code = idx_reg[0] ? cmd_reg.data[3:0] : cmd_reg.data[7:4];
            end
            KIND_A26:
            begin
                case (idx_reg)
                    2'd0:    code = {1'b0, cmd_reg.data[7:5]};
                    2'd1:    code = {1'b0, cmd_reg.data[4:2]};
                    default: code = {1'b0, cmd_reg.data[1], 1'b0, cmd_reg.data[0]};
                endcase
            end
            KIND_A2:
            begin
                case (idx_reg)
                    2'd0:    code = {2'b0, cmd_reg.data[7:6]};
                    2'd1:    code = {2'b0, cmd_reg.data[5:4]};
                    2'd2:    code = {2'b0, cmd_reg.data[3:2]};
                    default: code = {2'b0, cmd_reg.data[1:0]};
                endcase
            end
            default:
            begin
                code = 4'd0;
            end
        endcase
    end

    always_comb
    begin
        mag      = (cmd_reg.kind == KIND_A4) ? code[2:0] : {1'b0, code[1:0]};
        prod     = {6'd0, mag} * {3'd0, step_reg};
        neg      = 1'b0;
        do_move  = 1'b1;
        delta    = {1'b0, prod[7:0]} + {4'd0, half};
        step_adp = step_reg;
        case (cmd_reg.kind)
            KIND_A4:
            begin
                neg = code[3];
                if (mag == 3'd0)
                begin
                    step_adp = halve_min1(step_reg);
                end
                else if (mag >= 3'd5)
                begin
                    step_adp = sat_double(step_reg, CEIL_A4);
                end
            end
            KIND_A26:
            begin
                neg = code[2];
                if (mag == 3'd0)
                begin
                    step_adp = halve_min1(step_reg);
                end
                else if (mag == 3'd3)
                begin
                    step_adp = sat_double(step_reg, CEIL_A26);
                end
            end
            default:
            begin
                neg = code[1];
                if (code[0])
                begin
                    delta    = {3'd0, step_reg} + {4'd0, half};
                    step_adp = sat_double(step_reg, CEIL_A2);
                end
                else if (half == 5'd0)
                begin
                    do_move  = 1'b0;
                    step_adp = STEP_RESET;
                end
                else
                begin
                    delta    = {4'd0, half};
                    step_adp = {1'b0, half};
                end
            end
        endcase
        moved = neg ? ({3'd0, ref_reg} - {2'd0, delta}) : ({3'd0, ref_reg} + {2'd0, delta});
        if (!do_move)
        begin
            ref_adp = ref_reg;
        end
        else if (moved[10])
        begin
            ref_adp = 8'h00;
        end
        else if (moved[9:8] != 2'd0)
        begin
            ref_adp = 8'hFF;
        end
        else
        begin
            ref_adp = moved[7:0];
        end
    end

    always_comb
    begin
        ref_next   = ref_reg;
        step_next  = step_reg;
        phase_next = phase_reg;
        hold_next  = hold_reg;
        produce    = 1'b0;
        sample     = expand_u8(cmd_reg.data);
        if (step_fire)
        begin
            case (cmd_reg.kind)
                KIND_U8:
                begin
                    produce = 1'b1;
                end
                KIND_S16:
                begin
                    if (phase_reg)
                    begin
                        produce    = 1'b1;
                        sample     = {cmd_reg.data, hold_reg};
                        phase_next = 1'b0;
                    end
                    else
                    begin
                        hold_next  = cmd_reg.data;
                        phase_next = 1'b1;
                    end
                end
                KIND_A4, KIND_A26, KIND_A2:
                begin
                    produce = 1'b1;
                    if (cmd_reg.start)
                    begin
                        ref_next = cmd_reg.data;
                    end
                    else
                    begin
                        ref_next  = ref_adp;
                        step_next = step_adp;
                        sample    = expand_u8(ref_adp);
                    end
                end
                default:
                begin
                    produce = 1'b0;
                end
            endcase
        end
        if (pop && head_cmd.start)
        begin
            ref_next   = REF_RESET;
            step_next  = STEP_RESET;
            phase_next = 1'b0;
            hold_next  = 8'd0;
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (pop)
        begin
            busy_next = 1'b1;
            idx_next  = 2'd0;
        end
        else if (last_step)
        begin
            busy_next = 1'b0;
        end
        else if (step_fire)
        begin
            idx_next = idx_reg + 2'd1;
        end

        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        if (produce)
        begin
            out_valid_next = 1'b1;
            out_data_next  = sample;
            out_last_next  = (idx_reg == cmd_reg.last_idx);
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            idx_reg       <= 2'd0;
            ref_reg       <= REF_RESET;
            step_reg      <= STEP_RESET;
            phase_reg     <= 1'b0;
            hold_reg      <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            idx_reg       <= idx_next;
            ref_reg       <= ref_next;
            step_reg      <= step_next;
            phase_reg     <= phase_next;
            hold_reg      <= hold_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cmd_reg <= head_cmd;
        end
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ----- rtl/voc_adpcm_pcm_sample_decoder.sv -----
// Top level of the sound sample decoder: front end, command queue and back end.
`timescale 1ns / 1ps

// The back end decodes the codes of a byte in turn, one sample each: two, three
// or four for a byte in the 4-bit, 2.6-bit or 2-bit ADPCM modes, since each code
// moves the shared reference before the next code can use it, and one for an
// unsigned 8-bit PCM byte and an ADPCM chunk-start byte. A 16-bit PCM pair yields
// one sample from its second byte. Bytes in an undefined mode give no transfer. The
// front end writes a two-entry queue, so input bytes are taken while the back
// end decodes and while a finished sample waits in the output register.
module voc_adpcm_pcm_sample_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_data,   // codec_mode
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // data_byte
    input  logic        s_tuser,    // chunk_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // sample_value (signed)
    output logic        m_tlast     // last_of_byte
);
    import voc_pkg::*;

    logic push;
    cmd_t push_cmd;
    logic q_ready;
    logic pop;
    logic q_valid;
    cmd_t head_cmd;

    voc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .push      (push),
        .push_cmd  (push_cmd),
        .q_ready   (q_ready)
    );

    voc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .q_ready  (q_ready),
        .pop      (pop),
        .q_valid  (q_valid),
        .head_cmd (head_cmd)
    );

    voc_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .head_cmd (head_cmd),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

// ----- rtl/voc_checker.sv -----
// Port-level assertions for the sound sample decoder and their bind statement.
`timescale 1ns / 1ps

module voc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        cfg_valid,
    input logic        cfg_ready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tlast
);

    // A stalled sample stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("Output transfer was withdrawn while stalled.");

    // A stalled sample keeps its payload.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
        else $error("Output payload changed while stalled.");

    // The configuration register always takes a write.
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("Configuration write was not taken.");

    // The samples of one byte follow each other without a gap.
    a_burst: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid)
        else $error("Gap inside the samples of one byte.");

endmodule

bind voc_adpcm_pcm_sample_decoder voc_checker u_voc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
);

// ----- test/tb.sv -----
// Self-checking testbench of the sound sample decoder with a built-in decode predictor.
`timescale 1ns / 1ps

module tb;

    import voc_pkg::*;

    localparam int QUIET_LIMIT = 4000;
    localparam int HOLD_CYCLES = 200;
    localparam int SETTLE_CYCLES = 20;

    typedef struct {
        logic [7:0] data;
        logic       first;
    } byte_item_t;

    typedef struct {
        logic [15:0] sample;
        logic        last;
    } pcm_sample_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_data = MODE_ADPCM4;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tlast;

    byte_item_t  pending_bytes[$];
    pcm_sample_t expected_samples[$];
    byte_item_t  next_byte;
    pcm_sample_t want;

    logic [2:0]  cur_mode = MODE_ADPCM4;
    logic [7:0]  lvl = REF_RESET;
    logic [5:0]  step = STEP_RESET;
    logic        s16_phase = 1'b0;
    logic [7:0]  low_hold = 8'h00;

    int          errors = 0;
    int          quiet_cycles = 0;
    int          burst_left = 0;
    int          gap_left = 0;
    int          stall_style = 0;
    int          style_left = 0;
    int          hold_left = 0;
    logic        hold_go = 1'b0;
    logic        hold_done = 1'b0;
    logic [1:0]  stall_phase = 2'd0;

    voc_adpcm_pcm_sample_decoder uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic void push_level(input logic last);
        pcm_sample_t s;
        s.sample = 16'((int'(lvl) - 128) * 128);
        s.last = last;
        expected_samples.push_back(s);
    endfunction

    function automatic void move_level(input int delta, input logic neg);
        int r;
        r = neg ? int'(lvl) - delta : int'(lvl) + delta;
        if (r < 0)
        begin
            r = 0;
        end
        if (r > 255)
        begin
            r = 255;
        end
        lvl = r[7:0];
    endfunction

    function automatic void step_up(input int ceiling);
        int d;
        d = int'(step) * 2;
        step = (d > ceiling) ? ceiling[5:0] : d[5:0];
    endfunction

    function automatic void step_down();
        step = (step >> 1 == 6'd0) ? 6'd1 : step >> 1;
    endfunction

    function automatic void decode_byte(input logic [7:0] b, input logic first);
        pcm_sample_t s;
        int n;
        int mag;
        logic [3:0] c;
        if (first)
        begin
            lvl = REF_RESET;
            step = STEP_RESET;
            s16_phase = 1'b0;
            low_hold = 8'h00;
        end
        case (cur_mode)
            MODE_PCM_U8:
            begin
                s.sample = 16'((int'(b) - 128) * 128);
                s.last = 1'b1;
                expected_samples.push_back(s);
            end
            MODE_PCM_S16:
            begin
                if (!s16_phase)
                begin
                    low_hold = b;
                    s16_phase = 1'b1;
                end
                else
                begin
                    s16_phase = 1'b0;
                    s.sample = {b, low_hold};
                    s.last = 1'b1;
                    expected_samples.push_back(s);
                end
            end
            MODE_ADPCM4, MODE_ADPCM26, MODE_ADPCM2:
            begin
                if (first)
                begin
                    lvl = b;
                    push_level(1'b1);
                end
                else
                begin
                    n = (cur_mode == MODE_ADPCM4) ? 2 : (cur_mode == MODE_ADPCM26) ? 3 : 4;
                    for (int i = 0; i < n; i++)
                    begin
                        if (cur_mode == MODE_ADPCM4)
                        begin
                            c = (i == 0) ? b[7:4] : b[3:0];
                            mag = int'(c[2:0]);
                            move_level(((mag * int'(step)) & 255) + int'(step) / 2, c[3]);
                            if (mag == 0)
                            begin
                                step_down();
                            end
                            else if (mag >= 5)
                            begin
                                step_up(int'(CEIL_A4));
                            end
                        end
                        else if (cur_mode == MODE_ADPCM26)
                        begin
                            c = (i == 0) ? {1'b0, b[7:5]} :
                                (i == 1) ? {1'b0, b[4:2]} : {1'b0, b[1], 1'b0, b[0]};
                            mag = int'(c[1:0]);
                            move_level(((mag * int'(step)) & 255) + int'(step) / 2, c[2]);
                            if (mag == 0)
                            begin
                                step_down();
                            end
                            else if (mag == 3)
                            begin
                                step_up(int'(CEIL_A26));
                            end
                        end
                        else
                        begin
                            c = {2'b00, b[7 - 2 * i -: 2]};
                            if (c[0])
                            begin
                                move_level(int'(step) + int'(step) / 2, c[1]);
                                step_up(int'(CEIL_A2));
                            end
                            else
                            begin
                                step = step >> 1;
                                if (step == 6'd0)
                                begin
                                    step = 6'd1;
                                end
                                else
                                begin
                                    move_level(int'(step), c[1]);
                                end
                            end
                        end
                        push_level(i == n - 1);
                    end
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic logic [7:0] rand_byte();
        if ($urandom_range(0, 3) != 0)
        begin
            return 8'($urandom_range(0, 255));
        end
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h77;
            3: return 8'hF7;
            4: return 8'h55;
            5: return 8'hAA;
            6: return 8'h7F;
            default: return 8'h80;
        endcase
    endfunction

    task automatic add(input logic [7:0] data, input logic first);
        byte_item_t it;
        it.data = data;
        it.first = first;
        pending_bytes.push_back(it);
    endtask

    task automatic set_mode(input logic [2:0] mode);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= mode;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (pending_bytes.size() != 0 || s_tvalid || expected_samples.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic queue_random(input int count);
        int made;
        int len;
        made = 0;
        while (made < count)
        begin
            len = $urandom_range(1, 10);
            for (int k = 0; k < len && made < count; k++)
            begin
                add(rand_byte(), (k == 0) ? ($urandom_range(0, 7) != 0)
                                          : ($urandom_range(0, 30) == 0));
                made++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= 8'h00;
            s_tuser <= 1'b0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (gap_left > 0 || pending_bytes.size() == 0)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                end
                s_tvalid <= 1'b0;
            end
            else
            begin
                next_byte = pending_bytes.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= next_byte.data;
                s_tuser <= next_byte.first;
                if (burst_left > 0)
                begin
                    burst_left--;
                end
                else
                begin
                    burst_left = $urandom_range(0, 15);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            stall_phase <= stall_phase + 2'd1;
            if (hold_go && !hold_done)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (style_left == 0)
            begin
                stall_style = $urandom_range(0, 3);
                style_left = $urandom_range(16, 80);
            end
            else
            begin
                style_left--;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                case (stall_style)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom_range(0, 1));
                    2: m_tready <= (stall_phase == 2'd0);
                    default: m_tready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                cur_mode = cfg_data;
            end
            if (s_tvalid && s_tready)
            begin
                decode_byte(s_tdata, s_tuser);
            end
            if (m_tvalid && m_tready)
            begin
                if (expected_samples.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                    begin
                        $display("unexpected sample %h last %b", m_tdata, m_tlast);
                    end
                end
                else
                begin
                    want = expected_samples.pop_front();
                    if (m_tdata !== want.sample || m_tlast !== want.last)
                    begin
                        errors++;
                        if (errors <= 10)
                        begin
                            $display("mismatch: expected %h last %b, got %h last %b",
                                     want.sample, want.last, m_tdata, m_tlast);
                        end
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Decoding from the reset state without a chunk start, clamping at the top, then a chunk start and a descent.
        add(8'h00, 1'b0);
        add(8'h77, 1'b0);
        add(8'h77, 1'b0);
        add(8'h77, 1'b0);
        add(8'hFF, 1'b1);
        add(8'hFF, 1'b0);
        add(8'h88, 1'b0);
        drain();

        set_mode(MODE_ADPCM2);
        add(8'h00, 1'b1);
        add(8'h55, 1'b0);
        add(8'h55, 1'b0);
        add(8'hFF, 1'b0);
        add(8'hAA, 1'b0);
        drain();

        // The step left by the 2-bit mode is kept when the 4-bit mode takes over.
        set_mode(MODE_ADPCM4);
        add(8'h70, 1'b0);
        drain();

        set_mode(MODE_ADPCM26);
        add(8'h80, 1'b1);
        add(8'h6D, 1'b0);
        add(8'hFF, 1'b0);
        add(8'h00, 1'b0);
        drain();

        set_mode(MODE_PCM_U8);
        add(8'h00, 1'b0);
        add(8'hFF, 1'b1);
        add(8'h80, 1'b0);
        drain();

        // A chunk start in the middle of a pair drops the held low byte.
        set_mode(MODE_PCM_S16);
        add(8'h00, 1'b1);
        add(8'h80, 1'b0);
        add(8'hFF, 1'b0);
        add(8'h12, 1'b1);
        add(8'h7F, 1'b0);
        drain();

        // Undefined modes ignore data, but a chunk start still clears the state.
        set_mode(3'd6);
        add(8'h34, 1'b0);
        add(8'h56, 1'b1);
        drain();
        set_mode(3'd7);
        add(8'hAA, 1'b0);
        drain();
        set_mode(MODE_ADPCM4);
        add(8'h9C, 1'b0);
        drain();

        set_mode(MODE_ADPCM2);
        hold_go <= 1'b1;
        queue_random(16);
        drain();

        set_mode(MODE_ADPCM4);
        queue_random(14);
        drain();

        set_mode(MODE_ADPCM26);
        queue_random(14);
        drain();

        set_mode(MODE_PCM_U8);
        queue_random(12);
        drain();

        set_mode(MODE_PCM_S16);
        queue_random(13);
        drain();

        set_mode(3'd5);
        queue_random(4);
        drain();

        set_mode(MODE_ADPCM26);
        queue_random(14);
        drain();

        set_mode(MODE_ADPCM2);
        queue_random(13);
        drain();

        set_mode(MODE_ADPCM4);
        queue_random(13);
        drain();

        set_mode(MODE_PCM_S16);
        queue_random(12);
        drain();

        set_mode(MODE_PCM_U8);
        queue_random(6);
        drain();

        if (errors == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
